// ----- design/sedf_pkg.sv -----
`default_nettype none

package sedf_pkg;

  // Framing bytes on the wire.
  localparam logic [7:0] SYNC_BYTE      = 8'd225;
  localparam logic [7:0] ESC_BYTE       = 8'd224;
  localparam logic [7:0] ESC_SYNC_CODE  = 8'd1;
  localparam logic [7:0] ACK_FLAG       = 8'h80;
  localparam logic [7:0] SEQ_MASK       = 8'h7F;

  // Reset values of the register and of the receive history.
  localparam logic [7:0] MAX_LEN_RESET  = 8'd255;
  localparam logic [7:0] LAST_SEQ_RESET = 8'd255;

  // CRC-16/MODBUS, reflected form.
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] TALLY_MAX     = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_SEQ,
    PH_DATA,
    PH_CRC1,
    PH_CRC2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RECEIVING,
    ST_COMPLETE
  } status_t;

  typedef enum logic [3:0] {
    EV_NONE,
    EV_FRAME,
    EV_PAYLOAD,
    EV_NEW,
    EV_DUP,
    EV_SYNC,
    EV_ACK_MATCH,
    EV_ACK_IGN,
    EV_CRC_ERR,
    EV_LEN_REJ
  } event_t;

  typedef struct packed {
    status_t     rx_status;
    event_t      event_res;
    logic [7:0]  data_byte;
    logic [7:0]  payload_length;
    logic [7:0]  seq_number;
    logic        send_ack;
    logic [7:0]  ack_seq_byte;
    logic        tx_acked;
    logic [15:0] crc_error_count;
  } result_t;

  // One byte through the CRC, bit by bit, LSB first.
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// ----- design/sedf_if.sv -----
`default_nettype none

// Input channel: one received serial byte per word.
interface sedf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [7:0] tx_seq_outstanding;

  modport source(output valid, output rx_byte, output tx_seq_outstanding, input ready);
  modport sink(input valid, input rx_byte, input tx_seq_outstanding, output ready);
endinterface

// Result channel: one result word per input word.
interface sedf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  rx_status;
  logic [3:0]  event_res;
  logic [7:0]  data_byte;
  logic [7:0]  payload_length;
  logic [7:0]  seq_number;
  logic        send_ack;
  logic [7:0]  ack_seq_byte;
  logic        tx_acked;
  logic [15:0] crc_error_count;

  modport source(output valid, output rx_status, output event_res, output data_byte,
                 output payload_length, output seq_number, output send_ack,
                 output ack_seq_byte, output tx_acked, output crc_error_count,
                 input ready);
  modport sink(input valid, input rx_status, input event_res, input data_byte,
               input payload_length, input seq_number, input send_ack,
               input ack_seq_byte, input tx_acked, input crc_error_count,
               output ready);
endinterface

// Configuration channel: write data for the maximum frame length register.
interface sedf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/sync_escape_crc_packet_deframer.sv -----
// Receive deframer for a byte-stuffed serial packet link. Each input word carries one raw
// received byte plus the sequence number of the last data packet we sent; each input word
// yields exactly one result word. A frame is sync (225), length L, sequence byte, L-1 payload
// bytes and a CRC-16/MODBUS trailer (low byte first); byte 224 escapes the next byte, and
// 224 followed by 1 stands for a literal 225. Payload bytes come out at once, marked tentative,
// and the frame end either commits them (good CRC) or discards them. The block reports new
// packets, duplicates, sync requests and ACKs, asks for ACK replies, and keeps a saturating CRC
// error count. Throughput is one word per clock while the output is not stalled: each byte passes
// through an input register, one combinational decode step (frame state machine plus a byte-wide
// CRC update), and a result register. The result register and the input register together let
// a new byte be taken while a finished result is still waiting on the output. The maximum frame
// length register may be written only while no word is in flight; writes are always accepted.
`default_nettype none

module sync_escape_crc_packet_deframer
  import sedf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  sedf_in_if.sink     in_ch,
  sedf_out_if.source  out_ch,
  sedf_cfg_if.sink    cfg
);

  // Configuration register.
  logic [7:0] max_frame_length;

  // Input register stage.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic [7:0] s1_txs;

  // Result register stage.
  logic       out_valid;
  result_t    res;
  result_t    res_next;

  // Decoder state.
  logic        escape_pending;
  phase_t      phase;
  logic [7:0]  payload_remaining;
  logic [7:0]  payload_count;
  logic [7:0]  frame_seq;
  logic [15:0] crc_acc;
  logic [7:0]  last_rx_seq;
  logic [15:0] error_tally;

  logic        escape_pending_next;
  phase_t      phase_next;
  logic [7:0]  payload_remaining_next;
  logic [7:0]  payload_count_next;
  logic [7:0]  frame_seq_next;
  logic [15:0] crc_acc_next;
  logic [7:0]  last_rx_seq_next;
  logic [15:0] error_tally_next;

  // Byte classification.
  logic        dec;
  logic        sync;
  logic [7:0]  cb;
  logic [15:0] crc_new;
  logic        crc_ok;
  logic        len_bad;
  logic        ack_match;

  logic advance;
  logic fire;

  // The result register moves when it is empty or being drained; the input register feeds it.
  assign advance      = !out_valid || out_ch.ready;
  assign fire         = s1_valid && advance;
  assign in_ch.ready  = !s1_valid || advance;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= MAX_LEN_RESET;
    end else if (cfg.valid) begin
      max_frame_length <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte <= in_ch.rx_byte;
      s1_txs  <= in_ch.tx_seq_outstanding;
    end
  end

  // Unstuffing: a raw sync always restarts a frame, even right after an escape.
  always_comb begin
    escape_pending_next = escape_pending;
    dec  = 1'b0;
    sync = 1'b0;
    cb   = s1_byte;
    if (escape_pending) begin
      escape_pending_next = 1'b0;
      if (s1_byte == SYNC_BYTE) begin
        sync = 1'b1;
      end else begin
        dec = 1'b1;
        if (s1_byte == ESC_SYNC_CODE) begin
          cb = SYNC_BYTE;
        end
      end
    end else if (s1_byte == SYNC_BYTE) begin
      sync = 1'b1;
    end else if (s1_byte == ESC_BYTE) begin
      escape_pending_next = 1'b1;
    end else begin
      dec = 1'b1;
    end
  end

  // The sequence byte starts a fresh CRC; every later byte continues the running one.
  assign crc_new   = crc_update((phase == PH_SEQ) ? CRC_INIT : crc_acc, cb);
  assign crc_ok    = (crc_new == 16'h0000);
  assign len_bad   = (cb == 8'd0) || (cb > max_frame_length);
  assign ack_match = ((frame_seq & SEQ_MASK) == (s1_txs & SEQ_MASK));

  // Next state of the frame decoder.
  always_comb begin
    phase_next             = phase;
    payload_remaining_next = payload_remaining;
    payload_count_next     = payload_count;
    frame_seq_next         = frame_seq;
    crc_acc_next           = crc_acc;
    last_rx_seq_next       = last_rx_seq;
    error_tally_next       = error_tally;
    if (sync) begin
      phase_next = PH_LEN;
    end else if (dec) begin
      case (phase)
        PH_LEN: begin
          if (len_bad) begin
            phase_next = PH_IDLE;
          end else begin
            payload_remaining_next = cb - 8'd1;
            phase_next             = PH_SEQ;
          end
        end
        PH_SEQ: begin
          frame_seq_next     = cb;
          payload_count_next = 8'd0;
          crc_acc_next       = crc_new;
          phase_next         = (payload_remaining != 8'd0) ? PH_DATA : PH_CRC1;
        end
        PH_DATA: begin
          crc_acc_next           = crc_new;
          payload_count_next     = payload_count + 8'd1;
          payload_remaining_next = payload_remaining - 8'd1;
          if (payload_remaining == 8'd1) begin
            phase_next = PH_CRC1;
          end
        end
        PH_CRC1: begin
          crc_acc_next = crc_new;
          phase_next   = PH_CRC2;
        end
        PH_CRC2: begin
          phase_next = PH_IDLE;
          if (crc_ok) begin
            // ACK frames never touch the receive history.
            if (!frame_seq[7]) begin
              if (frame_seq == 8'd0) begin
                last_rx_seq_next = 8'd0;
              end else if (frame_seq != last_rx_seq) begin
                last_rx_seq_next = frame_seq;
              end
            end
          end else if (error_tally != TALLY_MAX) begin
            error_tally_next = error_tally + 16'd1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Result word for the current byte.
  always_comb begin
    res_next                 = '0;
    res_next.rx_status       = ST_RECEIVING;
    res_next.event_res       = EV_NONE;
    res_next.ack_seq_byte    = ACK_FLAG;
    res_next.crc_error_count = error_tally_next;
    if (sync) begin
      res_next.event_res = EV_FRAME;
    end else if (dec) begin
      case (phase)
        PH_LEN: begin
          if (len_bad) begin
            res_next.rx_status = ST_IDLE;
            res_next.event_res = EV_LEN_REJ;
          end else begin
            res_next.event_res = EV_FRAME;
          end
        end
        PH_SEQ, PH_CRC1: begin
          res_next.event_res = EV_FRAME;
        end
        PH_DATA: begin
          res_next.event_res = EV_PAYLOAD;
          res_next.data_byte = cb;
        end
        PH_CRC2: begin
          res_next.payload_length = payload_count;
          res_next.seq_number     = frame_seq;
          if (crc_ok) begin
            res_next.rx_status = ST_COMPLETE;
            if (frame_seq[7]) begin
              if (ack_match) begin
                res_next.event_res = EV_ACK_MATCH;
                res_next.tx_acked  = 1'b1;
              end else begin
                res_next.event_res = EV_ACK_IGN;
              end
            end else begin
              res_next.send_ack     = 1'b1;
              res_next.ack_seq_byte = frame_seq | ACK_FLAG;
              if (frame_seq == 8'd0) begin
                res_next.event_res = EV_SYNC;
              end else if (frame_seq == last_rx_seq) begin
                res_next.event_res = EV_DUP;
              end else begin
                res_next.event_res = EV_NEW;
              end
            end
          end else begin
            res_next.rx_status = ST_IDLE;
            res_next.event_res = EV_CRC_ERR;
          end
        end
        default: begin
          res_next.rx_status = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending    <= 1'b0;
      phase             <= PH_IDLE;
      payload_remaining <= 8'd0;
      payload_count     <= 8'd0;
      frame_seq         <= 8'd0;
      crc_acc           <= CRC_INIT;
      last_rx_seq       <= LAST_SEQ_RESET;
      error_tally       <= 16'd0;
    end else if (fire) begin
      escape_pending    <= escape_pending_next;
      phase             <= phase_next;
      payload_remaining <= payload_remaining_next;
      payload_count     <= payload_count_next;
      frame_seq         <= frame_seq_next;
      crc_acc           <= crc_acc_next;
      last_rx_seq       <= last_rx_seq_next;
      error_tally       <= error_tally_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.rx_status       = res.rx_status;
  assign out_ch.event_res       = res.event_res;
  assign out_ch.data_byte       = res.data_byte;
  assign out_ch.payload_length  = res.payload_length;
  assign out_ch.seq_number      = res.seq_number;
  assign out_ch.send_ack        = res.send_ack;
  assign out_ch.ack_seq_byte    = res.ack_seq_byte;
  assign out_ch.tx_acked        = res.tx_acked;
  assign out_ch.crc_error_count = res.crc_error_count;

  // While in the payload phase there is always at least one payload byte still to come.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (payload_remaining != 8'd0))
    else $error("payload phase entered with nothing left to receive");

  // The CRC error tally never goes backwards.
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (error_tally >= $past(error_tally)))
    else $error("CRC error tally decreased");

  // An ACK request only comes with a good data frame and carries the ACK flag.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.send_ack) |->
      (res.ack_seq_byte[7] && res.rx_status == ST_COMPLETE &&
       (res.event_res == EV_NEW || res.event_res == EV_DUP || res.event_res == EV_SYNC)))
    else $error("ACK request without a good data frame");

  // A matched ACK is only reported for a good frame.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.tx_acked) |->
      (res.event_res == EV_ACK_MATCH && res.rx_status == ST_COMPLETE && !res.send_ack))
    else $error("ACK match flagged outside a good ACK frame");

endmodule

`default_nettype wire
